// File: sv/mrfp_pkg.sv
// shared constants for the meter record field parser
`timescale 1ns / 1ps

package mrfp_pkg;

  // reading width, limited to 32 bits for the saturation point
  localparam int ReadingBits = 32;
  localparam int RbEff       = (ReadingBits > 32) ? 32 : ReadingBits;
  localparam int MagBits     = RbEff - 1;
  localparam int IdxBits     = 5;

  localparam logic [MagBits-1:0] PosMax = {MagBits{1'b1}};

  typedef logic [7:0] byte_t;
  typedef logic [1:0] qty_t;
  typedef logic [1:0] status_t;

  localparam qty_t QtyWatts = 2'd0;
  localparam qty_t QtyVolts = 2'd1;
  localparam qty_t QtyAmps  = 2'd2;
  localparam qty_t QtyPf    = 2'd3;

  localparam status_t StatusOk     = 2'd0;
  localparam status_t StatusNoHash = 2'd1;
  localparam status_t StatusBadPfx = 2'd2;

  localparam logic [IdxBits-1:0] TokWatts = 5'd3;
  localparam logic [IdxBits-1:0] TokVolts = 5'd4;
  localparam logic [IdxBits-1:0] TokAmps  = 5'd5;
  localparam logic [IdxBits-1:0] TokPf    = 5'd16;
  localparam logic [IdxBits-1:0] TokMax   = 5'd31;

  localparam logic [9:0] DivWatts = 10'd10;
  localparam logic [9:0] DivVolts = 10'd10;
  localparam logic [9:0] DivAmps  = 10'd1000;
  localparam logic [9:0] DivPf    = 10'd100;

  localparam byte_t ChHash  = 8'h23;
  localparam byte_t ChD     = 8'h64;
  localparam byte_t ChComma = 8'h2C;
  localparam byte_t ChSemi  = 8'h3B;
  localparam byte_t ChPlus  = 8'h2B;
  localparam byte_t ChMinus = 8'h2D;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChNine  = 8'h39;
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChCr    = 8'h0D;

endpackage

// File: sv/meter_record_field_parser_unit.sv
// top level of the meter record field parser
`timescale 1ns / 1ps

// meter record field parser
// input channel: in_valid / in_stall carry one received character per item
// (in_rx_byte). bytes before the first '#' other than ';' are ignored, the
// line must start "#d," and the rest is split on commas, empty tokens skipped.
// tokens 3, 4, 5 and 16 are parsed atoi-style and reported as watts, volts,
// amps or power factor on out_quantity / out_reading; ';' ends the line and
// reports out_line_status with out_line_end set.
// an item causes zero or one result; the result channel out_valid / out_stall
// carries it.
// the result is registered: the input register feeds the result register
// through the decode logic. throughput: one item per cycle while no result
// is stalled; the byte is decoded and the running accumulator (multiply by
// ten, add, saturate) updated between the two registers.
// reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for '#'.
// while the receiver stalls a pending result, the held input item waits and
// in_stall goes high; input is taken again once the result is taken.

module meter_record_field_parser_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mrfp_pkg::byte_t        in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_value_valid,
  output mrfp_pkg::qty_t         out_quantity,
  output logic signed [31:0]     out_reading,
  output logic                   out_line_end,
  output mrfp_pkg::status_t      out_line_status
);
  import mrfp_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HASH,
    PH_D,
    PH_BODY,
    PH_BAD
  } line_phase_t;

  typedef enum logic [1:0] {
    NP_WS,
    NP_DIGITS,
    NP_DONE
  } num_phase_t;

  // input register
  logic        s1_valid_r;
  byte_t       s1_byte_r;

  // parser state
  line_phase_t         phase_r, phase_nxt;
  logic [IdxBits-1:0]  tok_idx_r, tok_idx_nxt;
  logic                tok_nonempty_r, tok_nonempty_nxt;
  num_phase_t          np_r, np_nxt;
  logic                neg_r, neg_nxt;
  logic [MagBits-1:0]  mag_r, mag_nxt;

  // result register
  logic        out_valid_r;
  logic        res_value_valid_r, res_value_valid_nxt;
  qty_t        res_qty_r, res_qty_nxt;
  logic [31:0] res_reading_r, res_reading_nxt;
  logic        res_end_r, res_end_nxt;
  status_t     res_status_r, res_status_nxt;

  logic advance;
  logic is_ws, is_digit;
  logic [3:0] digit;
  logic [MagBits+3:0] mag_x10;
  logic [MagBits-1:0] mag_acc;
  logic [9:0]  divisor;
  qty_t        tok_qty;
  logic        tok_kept;
  logic [31:0] tok_reading;

  // the result register can take a new result when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  assign is_ws    = (s1_byte_r == ChSpace) ||
                    ((s1_byte_r >= ChTab) && (s1_byte_r <= ChCr));
  assign is_digit = (s1_byte_r >= ChZero) && (s1_byte_r <= ChNine);
  assign digit    = 4'(s1_byte_r - ChZero);

  // running accumulator: m*10 + d via shifts, saturating at the positive max
  assign mag_x10 = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {{MagBits{1'b0}}, digit};
  assign mag_acc = (mag_x10 > {4'd0, PosMax}) ? PosMax : mag_x10[MagBits-1:0];

  // which token positions carry a quantity
  always_comb begin
    tok_qty = QtyWatts;
    divisor = '0;
    unique case (tok_idx_r)
      TokWatts: begin tok_qty = QtyWatts; divisor = DivWatts; end
      TokVolts: begin tok_qty = QtyVolts; divisor = DivVolts; end
      TokAmps:  begin tok_qty = QtyAmps;  divisor = DivAmps;  end
      TokPf:    begin tok_qty = QtyPf;    divisor = DivPf;    end
      default:  begin tok_qty = QtyWatts; divisor = '0;       end
    endcase
  end

  // a negative value is kept only while it stays above minus one unit
  always_comb begin
    tok_kept    = 1'b0;
    tok_reading = {{(32-MagBits){1'b0}}, mag_r};
    if (tok_nonempty_r && (divisor != '0)) begin
      if (!neg_r) begin
        tok_kept = 1'b1;
      end else if ({{(32-MagBits){1'b0}}, mag_r} < {22'd0, divisor}) begin
        tok_kept    = 1'b1;
        tok_reading = 32'd0 - {{(32-MagBits){1'b0}}, mag_r};
      end
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    tok_idx_nxt      = tok_idx_r;
    tok_nonempty_nxt = tok_nonempty_r;
    np_nxt           = np_r;
    neg_nxt          = neg_r;
    mag_nxt          = mag_r;
    res_value_valid_nxt = 1'b0;
    res_qty_nxt      = QtyWatts;
    res_reading_nxt  = '0;
    res_end_nxt      = 1'b0;
    res_status_nxt   = StatusOk;

    unique case (phase_r)
      PH_WAIT: begin
        if (s1_byte_r == ChHash) begin
          phase_nxt = PH_HASH;
        end else if (s1_byte_r == ChSemi) begin
          res_end_nxt    = 1'b1;
          res_status_nxt = StatusNoHash;
        end
      end
      PH_HASH, PH_D: begin
        if (phase_r == PH_HASH && s1_byte_r == ChD) begin
          phase_nxt = PH_D;
        end else if (phase_r == PH_D && s1_byte_r == ChComma) begin
          phase_nxt        = PH_BODY;
          tok_idx_nxt      = 5'd1;
          tok_nonempty_nxt = 1'b0;
          np_nxt           = NP_WS;
          neg_nxt          = 1'b0;
          mag_nxt          = '0;
        end else if (s1_byte_r == ChSemi) begin
          res_end_nxt    = 1'b1;
          res_status_nxt = StatusBadPfx;
          phase_nxt      = PH_WAIT;
        end else begin
          phase_nxt = PH_BAD;
        end
      end
      PH_BODY: begin
        if (s1_byte_r == ChComma || s1_byte_r == ChSemi) begin
          // close the token; empty tokens are not counted
          if (tok_nonempty_r) begin
            res_value_valid_nxt = tok_kept;
            if (tok_kept) begin
              res_qty_nxt     = tok_qty;
              res_reading_nxt = tok_reading;
            end
            if (tok_idx_r != TokMax) tok_idx_nxt = tok_idx_r + 5'd1;
          end
          tok_nonempty_nxt = 1'b0;
          np_nxt           = NP_WS;
          neg_nxt          = 1'b0;
          mag_nxt          = '0;
          if (s1_byte_r == ChSemi) begin
            res_end_nxt    = 1'b1;
            res_status_nxt = StatusOk;
            phase_nxt      = PH_WAIT;
          end
        end else begin
          tok_nonempty_nxt = 1'b1;
          unique case (np_r)
            NP_WS: begin
              if (is_ws) begin
                np_nxt = NP_WS;
              end else if (s1_byte_r == ChPlus || s1_byte_r == ChMinus) begin
                neg_nxt = (s1_byte_r == ChMinus);
                np_nxt  = NP_DIGITS;
              end else if (is_digit) begin
                np_nxt  = NP_DIGITS;
                mag_nxt = mag_acc;
              end else begin
                np_nxt = NP_DONE;
              end
            end
            NP_DIGITS: begin
              if (is_digit) mag_nxt = mag_acc;
              else          np_nxt  = NP_DONE;
            end
            default: begin
              np_nxt = np_r;
            end
          endcase
        end
      end
      default: begin
        if (s1_byte_r == ChSemi) begin
          res_end_nxt    = 1'b1;
          res_status_nxt = StatusBadPfx;
          phase_nxt      = PH_WAIT;
        end
      end
    endcase

    // any line end drops a partial number
    if (res_end_nxt) begin
      tok_nonempty_nxt = 1'b0;
      np_nxt           = NP_WS;
      neg_nxt          = 1'b0;
      mag_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= PH_WAIT;
      tok_idx_r      <= '0;
      tok_nonempty_r <= 1'b0;
      np_r           <= NP_WS;
      neg_r          <= 1'b0;
      mag_r          <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        if (in_valid) s1_byte_r <= in_rx_byte;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r && (res_value_valid_nxt || res_end_nxt);
        if (s1_valid_r) begin
          phase_r           <= phase_nxt;
          tok_idx_r         <= tok_idx_nxt;
          tok_nonempty_r    <= tok_nonempty_nxt;
          np_r              <= np_nxt;
          neg_r             <= neg_nxt;
          mag_r             <= mag_nxt;
          res_value_valid_r <= res_value_valid_nxt;
          res_qty_r         <= res_qty_nxt;
          res_reading_r     <= res_reading_nxt;
          res_end_r         <= res_end_nxt;
          res_status_r      <= res_status_nxt;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_valid = res_value_valid_r;
  assign out_quantity    = res_qty_r;
  assign out_reading     = res_reading_r;
  assign out_line_end    = res_end_r;
  assign out_line_status = res_status_r;

  // a result is either a value, a line end, or both
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_value_valid_r || res_end_r))
    else $error("empty result delivered");

  // status is only reported at line end
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_end_r) |-> (res_status_r == StatusOk))
    else $error("line status without line end");

  // a value closing a line can only come from a well formed body
  a_value_ok_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_value_valid_r && res_end_r) |-> (res_status_r == StatusOk))
    else $error("value reported on a bad line");

  // input is held back only while an item waits on a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

endmodule

// File: test/tb_meter_record_field_parser_unit.sv
// testbench for the meter record field parser: directed rows, random meter lines, scoreboard
`timescale 1ns / 1ps

module tb_meter_record_field_parser_unit;
  import mrfp_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CycleLimit = 200000;
  // roughly how many bytes of the random part should reach the parser
  localparam int ByteTarget = 1350;
  // saturation point of the accumulator, widened to the working width
  localparam logic [31:0] MagCeil = 32'(PosMax);

  typedef enum logic [2:0] {PhWait, PhHash, PhD, PhBody, PhBad} line_phase_e;
  typedef enum logic [1:0] {NumWs, NumDigits, NumDone} num_phase_e;

  // one result item as seen on the out_ ports
  typedef struct packed {
    logic               value_valid;
    qty_t               quantity;
    logic signed [31:0] reading;
    logic               line_end;
    status_t            line_status;
  } field_rec_t;

  // a directed row: the byte and, where typed, the result it must cause
  typedef struct packed {
    byte_t      ch;
    logic       typed;
    field_rec_t res;
  } stim_row_t;

  localparam field_rec_t NoRec = '0;

  // directed part: end before any hash, bad prefixes, empty tokens, negative
  // value kept just above the limit and one dropped exactly at it
  localparam stim_row_t DirTable [22] = '{
    '{ChSemi,  1'b1, '{1'b0, QtyWatts, 32'sd0, 1'b1, StatusNoHash}},
    '{8'hFF,   1'b0, NoRec},                          // ignored before hash
    '{ChHash,  1'b0, NoRec},
    '{8'h78,   1'b0, NoRec},                          // 'x' breaks the prefix
    '{ChSemi,  1'b1, '{1'b0, QtyWatts, 32'sd0, 1'b1, StatusBadPfx}},
    '{ChHash,  1'b0, NoRec},
    '{ChSemi,  1'b1, '{1'b0, QtyWatts, 32'sd0, 1'b1, StatusBadPfx}},
    '{ChHash,  1'b0, NoRec},
    '{ChD,     1'b0, NoRec},
    '{ChComma, 1'b0, NoRec},
    '{8'h61,   1'b0, NoRec},                          // 'a', token 1
    '{ChComma, 1'b0, NoRec},
    '{ChComma, 1'b0, NoRec},                          // empty token, not counted
    '{8'h62,   1'b0, NoRec},                          // 'b', token 2
    '{ChComma, 1'b0, NoRec},
    '{ChMinus, 1'b0, NoRec},
    '{8'h39,   1'b0, NoRec},                          // '9'
    '{ChComma, 1'b1, '{1'b1, QtyWatts, -32'sd9, 1'b0, StatusOk}},
    '{ChMinus, 1'b0, NoRec},
    '{8'h31,   1'b0, NoRec},                          // '1'
    '{ChZero,  1'b0, NoRec},
    '{ChSemi,  1'b1, '{1'b0, QtyWatts, 32'sd0, 1'b1, StatusOk}}  // -10 volts dropped
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  byte_t              in_rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_value_valid;
  qty_t               out_quantity;
  logic signed [31:0] out_reading;
  logic               out_line_end;
  status_t            out_line_status;

  meter_record_field_parser_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_valid (out_value_valid),
    .out_quantity    (out_quantity),
    .out_reading     (out_reading),
    .out_line_end    (out_line_end),
    .out_line_status (out_line_status)
  );

  // whole byte stream and the results it must produce, in order
  byte_t      rx_bytes [$];
  field_rec_t pending_fields [$];
  int         counted_bytes = 0;
  int         mismatches = 0;
  int         sent = 0;
  int         cyc = 0;

  // parser state mirror
  line_phase_e phase = PhWait;
  logic [4:0]  tok_idx = '0;
  logic        tok_nonempty = 1'b0;
  num_phase_e  num_ph = NumWs;
  logic        neg = 1'b0;
  logic [31:0] mag = '0;

  function automatic void clear_number();
    tok_nonempty = 1'b0;
    num_ph = NumWs;
    neg = 1'b0;
    mag = '0;
  endfunction

  // close the current token; 1 when its value is kept for output
  function automatic bit close_field(output qty_t q, output logic [31:0] r);
    logic [9:0] div;
    qty_t       code;
    bit         kept;
    kept = 1'b0;
    div = '0;
    code = QtyWatts;
    q = QtyWatts;
    r = '0;
    if (!tok_nonempty) return 1'b0;
    case (tok_idx)
      TokWatts: begin code = QtyWatts; div = DivWatts; end
      TokVolts: begin code = QtyVolts; div = DivVolts; end
      TokAmps:  begin code = QtyAmps;  div = DivAmps;  end
      TokPf:    begin code = QtyPf;    div = DivPf;    end
      default:  div = '0;
    endcase
    if (div != 0) begin
      // negative counts survive only while above minus one unit
      if (!neg) begin
        kept = 1'b1;
        r = mag;
      end else if (mag < 32'(div)) begin
        kept = 1'b1;
        r = -mag;
      end
      q = code;
    end
    if (tok_idx < TokMax) tok_idx = tok_idx + 5'd1;
    clear_number();
    return kept;
  endfunction

  // advance the mirror by one byte; 1 when a result item follows
  function automatic bit predict_byte(input byte_t c, output field_rec_t rec);
    qty_t        q;
    logic [31:0] r;
    logic [31:0] d;
    bit          vld;
    bit          fin;
    bit          take_digit;
    status_t     st;
    vld = 1'b0;
    fin = 1'b0;
    take_digit = 1'b0;
    st = StatusOk;
    q = QtyWatts;
    r = '0;
    case (phase)
      PhWait: begin
        if (c == ChHash) phase = PhHash;
        else if (c == ChSemi) begin
          fin = 1'b1;
          st = StatusNoHash;
        end
      end
      PhHash, PhD: begin
        if (phase == PhHash && c == ChD) phase = PhD;
        else if (phase == PhD && c == ChComma) begin
          phase = PhBody;
          tok_idx = 5'd1;
          clear_number();
        end else if (c == ChSemi) begin
          fin = 1'b1;
          st = StatusBadPfx;
          phase = PhWait;
        end else phase = PhBad;
      end
      PhBody: begin
        if (c == ChComma) vld = close_field(q, r);
        else if (c == ChSemi) begin
          vld = close_field(q, r);
          fin = 1'b1;
          phase = PhWait;
        end else begin
          // atoi: whitespace, optional sign, digits up to the first non-digit
          tok_nonempty = 1'b1;
          if (num_ph == NumWs) begin
            if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
              // still skipping
            end else if (c == ChPlus || c == ChMinus) begin
              neg = (c == ChMinus);
              num_ph = NumDigits;
            end else begin
              num_ph = NumDigits;
              take_digit = 1'b1;
            end
          end else if (num_ph == NumDigits) take_digit = 1'b1;
          if (take_digit) begin
            if (c >= ChZero && c <= ChNine) begin
              d = 32'(c - ChZero);
              if (mag > (MagCeil - d) / 32'd10) mag = MagCeil;
              else mag = mag * 32'd10 + d;
            end else num_ph = NumDone;
          end
        end
      end
      default: begin
        if (c == ChSemi) begin
          fin = 1'b1;
          st = StatusBadPfx;
          phase = PhWait;
        end
      end
    endcase
    if (fin) clear_number();
    if (!vld) begin
      q = QtyWatts;
      r = '0;
    end
    rec = '{vld, q, r, fin, st};
    return vld || fin;
  endfunction

  // queue one byte and whatever result it causes
  task automatic push_byte(input byte_t c);
    field_rec_t  rec;
    bit          got;
    got = predict_byte(c, rec);
    rx_bytes.push_back(c);
    if (got) pending_fields.push_back(rec);
    counted_bytes++;
  endtask

  function automatic byte_t rand_byte_but(input byte_t a, input byte_t b);
    byte_t c;
    do c = byte_t'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // sender: bursts of random length, random gaps, payload held while stalled
  int burst_left = 8;
  int gap_left = 0;
  int nxt;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
    end else begin
      nxt = sent + ((in_valid && !in_stall) ? 1 : 0);
      if (in_valid && !in_stall) sent <= nxt;
      if (in_valid && in_stall) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (nxt < rx_bytes.size()) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_bytes[nxt];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
    end
  end

  // receiver: stall mode is chosen at random and changes when its countdown runs out
  int stall_mode = 0;
  int mode_left = 50;
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else mode_left <= mode_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  // scoreboard: every taken result against the oldest pending one
  field_rec_t want;
  field_rec_t seen;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_value_valid, out_quantity, out_reading, out_line_end, out_line_status};
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected result vv=%0b q=%0d r=%0d end=%0b st=%0d", $time,
                 seen.value_valid, seen.quantity, seen.reading, seen.line_end,
                 seen.line_status);
        mismatches++;
      end else begin
        want = pending_fields.pop_front();
        if (seen !== want) begin
          $display("%0t: mismatch exp vv=%0b q=%0d r=%0d end=%0b st=%0d", $time,
                   want.value_valid, want.quantity, want.reading, want.line_end,
                   want.line_status);
          $display("%0t:          got vv=%0b q=%0d r=%0d end=%0b st=%0d", $time,
                   seen.value_valid, seen.quantity, seen.reading, seen.line_end,
                   seen.line_status);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    field_rec_t junk;
    bit         got;
    int         kind;
    int         ntok;
    int         nd;
    int         sgn;
    // directed rows: typed ones carry their own expectation, the rest use the mirror
    for (int i = 0; i < 22; i++) begin
      if (DirTable[i].typed) begin
        got = predict_byte(DirTable[i].ch, junk);
        rx_bytes.push_back(DirTable[i].ch);
        pending_fields.push_back(DirTable[i].res);
      end else push_byte(DirTable[i].ch);
    end
    counted_bytes = 0;
    // random lines: mostly well formed records with random tokens
    while (counted_bytes < ByteTarget) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(0, 3)) push_byte(rand_byte_but(ChHash, ChSemi));
        push_byte(ChHash);
        push_byte(ChD);
        push_byte(ChComma);
        ntok = ($urandom_range(0, 1) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 20);
        for (int t = 0; t < ntok; t++) begin
          if ($urandom_range(0, 7) != 0) begin
            repeat ($urandom_range(0, 2)) begin
              if ($urandom_range(0, 5) == 0) push_byte(ChSpace);
              else push_byte(byte_t'(ChTab + $urandom_range(0, 4)));
            end
            sgn = $urandom_range(0, 2);
            if (sgn == 1) push_byte(ChPlus);
            if (sgn == 2) push_byte(ChMinus);
            // negatives short so some fall under the limit, a few long runs saturate
            if (sgn == 2) nd = $urandom_range(0, 4);
            else if ($urandom_range(0, 9) == 0) nd = $urandom_range(9, 14);
            else nd = $urandom_range(0, 5);
            repeat (nd) push_byte(byte_t'(ChZero + $urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0) push_byte(rand_byte_but(ChComma, ChSemi));
          end
          if (t != ntok - 1 || $urandom_range(0, 3) == 0) push_byte(ChComma);
        end
        push_byte(ChSemi);
      end else if (kind < 85) begin
        // broken prefix, then junk up to the terminator
        push_byte(ChHash);
        if ($urandom_range(0, 1) == 0) begin
          push_byte(ChD);
          push_byte(rand_byte_but(ChComma, ChComma));
        end else push_byte(rand_byte_but(ChD, ChD));
        repeat ($urandom_range(0, 6)) push_byte(rand_byte_but(ChSemi, ChSemi));
        push_byte(ChSemi);
      end else begin
        // raw noise across the whole byte range
        repeat ($urandom_range(1, 12)) push_byte(byte_t'($urandom_range(0, 255)));
      end
    end
    // close whatever the noise left open
    push_byte(ChSemi);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (sent < rx_bytes.size()) @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
